@@ rtl/core/ksa_pkg.sv @@
// Shared types and constants for the key state autorepeat unit.
package ksa_pkg;

  // Sizing
  localparam int unsigned NUM_KEYS   = 512;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned ADDR_W     = $clog2(NUM_KEYS);
  localparam int unsigned KEY_W      = 9;
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned STEP_W     = $clog2(COUNT_BITS);

  localparam logic [COUNT_BITS-1:0] HOLD_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAIT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic is_down;
    logic is_push;
    logic is_release;
  } out_item_t;

  // One word of the per-key store
  typedef struct packed {
    logic                  raw;
    logic                  latch;
    logic                  frame;
    logic                  last;
    logic [COUNT_BITS-1:0] hold;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_WR,
    ST_SW_RD,
    ST_SW_WR,
    ST_Q_CHK,
    ST_Q_DIV,
    ST_Q_OUT
  } state_e;

endpackage

@@ rtl/core/key_state_autorepeat_unit.sv @@
// Per-key level tracking with typematic repeat, built around one key store.
// Press/release: read-modify-write of the key's entry; ready again once it is written back.
// Query: result offered from ST_Q_OUT after ST_Q_CHK, with ST_Q_DIV between when the repeat remainder
//   is needed (one bit per cycle through the shift-subtract unit).
// Frame tick: a read state and a write state per key (ST_SW_RD, ST_SW_WR) across the key store.
// Reset: a clearing pass over every key zeroes the key store; no beat is taken meanwhile.
module key_state_autorepeat_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ksa_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ksa_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [ksa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ksa_pkg::CFG_W-1:0]       cfg_data_i
);
  import ksa_pkg::*;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic                  key_ok_q, key_ok_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic [CFG_W-1:0]      wait_q, interval_q;
  logic                  down_q, down_d;
  logic                  rel_q, rel_d;
  logic                  push_q, push_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic [CFG_W-1:0]      rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  // Key store
  entry_t                key_mem_q [NUM_KEYS];
  entry_t                rd_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  entry_t                mem_wdata;

  logic [CFG_W:0]        trial;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: next state, store access and remainder unit
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    key_ok_d    = key_ok_q;
    idx_d       = idx_q;
    down_d      = down_q;
    rel_d       = rel_q;
    push_d      = push_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_raddr   = ADDR_W'(in_data_i.key);
    mem_wdata   = rd_q;
    trial       = {rem_q, div_q[COUNT_BITS-1]};

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = '0;
        if (idx_q == ADDR_W'(NUM_KEYS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          addr_d   = ADDR_W'(in_data_i.key);
          key_ok_d = 32'(in_data_i.key) < NUM_KEYS;
          unique case (in_data_i.kind)
            KIND_TICK: begin
              idx_d   = '0;
              state_d = ST_SW_RD;
            end
            KIND_QUERY: state_d = ST_Q_CHK;
            KIND_PRESS, KIND_RELEASE: state_d = ST_EV_WR;
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Event: update raw level (and latch on press) of the addressed key
      ST_EV_WR: begin
        mem_we = key_ok_q;
        if (kind_q == KIND_PRESS) begin
          mem_wdata.raw   = 1'b1;
          mem_wdata.latch = 1'b1;
        end else begin
          mem_wdata.raw = 1'b0;
        end
        state_d = ST_IDLE;
      end

      ST_SW_RD: begin
        mem_raddr = idx_q;
        state_d   = ST_SW_WR;
      end

      // Frame sweep: shift levels, count held frames, drop the latch
      ST_SW_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = idx_q;
        mem_wdata.last  = rd_q.frame;
        mem_wdata.frame = rd_q.raw | rd_q.latch;
        mem_wdata.latch = 1'b0;
        if (!(rd_q.raw | rd_q.latch)) begin
          mem_wdata.hold = '0;
        end else if (rd_q.hold != HOLD_MAX) begin
          mem_wdata.hold = rd_q.hold + 1'b1;
        end
        if (idx_q == ADDR_W'(NUM_KEYS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SW_RD;
        end
      end

      // Query: flags from the entry, decide whether a remainder is needed
      ST_Q_CHK: begin
        down_d  = key_ok_q & rd_q.frame;
        rel_d   = key_ok_q & !rd_q.frame & rd_q.last;
        div_d   = COUNT_BITS'(32'(rd_q.hold) - 32'(wait_q));
        rem_d   = '0;
        step_d  = '0;
        push_d  = 1'b0;
        state_d = ST_Q_OUT;
        priority if (!key_ok_q) begin
          push_d = 1'b0;
        end else if (rd_q.hold == COUNT_BITS'(1)) begin
          push_d = 1'b1;
        end else if (wait_q != '0 && interval_q != '0 &&
                     32'(rd_q.hold) > 32'(wait_q)) begin
          if (interval_q == CFG_W'(1)) begin
            push_d = 1'b1;
          end else begin
            state_d = ST_Q_DIV;
          end
        end else begin
          push_d = 1'b0;
        end
      end

      // Restoring remainder, one dividend bit per cycle
      ST_Q_DIV: begin
        if (trial >= {1'b0, interval_q}) begin
          rem_d = CFG_W'(trial - {1'b0, interval_q});
        end else begin
          rem_d = CFG_W'(trial);
        end
        div_d  = div_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(COUNT_BITS - 1)) begin
          push_d  = (rem_d == CFG_W'(1));
          state_d = ST_Q_OUT;
        end
      end

      ST_Q_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.is_down    = down_q;
          out_d.is_push    = push_q;
          out_d.is_release = rel_q;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      wait_q      <= '0;
      interval_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WAIT:     wait_q     <= cfg_data_i;
          REG_INTERVAL: interval_q <= cfg_data_i;
          default:      wait_q     <= wait_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    addr_q   <= addr_d;
    key_ok_q <= key_ok_d;
    down_q   <= down_d;
    rel_q    <= rel_d;
    push_q   <= push_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    out_q    <= out_d;
  end

  // Key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= key_mem_q[mem_raddr];
  end

endmodule

@@ rtl/core/ksa_checker.sv @@
// Port-level checks for the key state autorepeat unit, bound to the top level.
module ksa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  ksa_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  ksa_pkg::out_item_t            out_data_o
);
  import ksa_pkg::*;

  // A waiting input beat holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while waiting");

  // Every accepted beat leaves the unit busy, input ready low, in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A key cannot be down and released in the same frame
  a_down_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_down && out_data_o.is_release))
    else $error("down and release both set");

  // A key that is up has no hold count, so it never pushes
  a_push_needs_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_down |-> !out_data_o.is_push)
    else $error("push reported for a key that is up");

endmodule

bind key_state_autorepeat_unit ksa_checker u_ksa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/key_status_checker.sv @@
// Channel monitor for the key unit: predicts every query status and compares it.
`timescale 1ns / 1ps

module key_status_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  ksa_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  ksa_pkg::out_item_t            out_data_i,
  input  logic                          cfg_we_i,
  input  logic [ksa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ksa_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  import ksa_pkg::*;

  // Shadow copy of the per-key store and the repeat registers
  logic                  raw_lvl   [NUM_KEYS];
  logic                  tap_latch [NUM_KEYS];
  logic                  cur_lvl   [NUM_KEYS];
  logic                  prev_lvl  [NUM_KEYS];
  logic [COUNT_BITS-1:0] held      [NUM_KEYS];
  logic [CFG_W-1:0]      rep_wait;
  logic [CFG_W-1:0]      rep_iv;

  // Query statuses still owed by the block, oldest first
  out_item_t   status_q[$];
  out_item_t   owed;
  out_item_t   fresh;
  int unsigned fails;
  int unsigned checked;
  int unsigned k;

  // First held frame, or a typematic frame once the wait has run out
  function automatic logic push_due(input logic [COUNT_BITS-1:0] cnt);
    int unsigned c, w, iv;
    c  = cnt;
    w  = rep_wait;
    iv = rep_iv;
    if (c == 1) return 1'b1;
    if (w > 0 && iv > 0 && c > w && (iv == 1 || (c - w) % iv == 1)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic check_flag(input string name, input logic want, input logic got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < NUM_KEYS; k++) begin
        raw_lvl[k]   = 1'b0;
        tap_latch[k] = 1'b0;
        cur_lvl[k]   = 1'b0;
        prev_lvl[k]  = 1'b0;
        held[k]      = '0;
      end
      rep_wait = '0;
      rep_iv   = '0;
      status_q.delete();
      fails   = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Result side: compare against the oldest owed status
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          fails++;
          $display("%0t: status beat with nothing expected, actual %b", $time, out_data_i);
        end else begin
          owed = status_q.pop_front();
          check_flag("is_down", owed.is_down, out_data_i.is_down);
          check_flag("is_push", owed.is_push, out_data_i.is_push);
          check_flag("is_release", owed.is_release, out_data_i.is_release);
          checked++;
        end
      end

      // Register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WAIT) rep_wait = cfg_data_i;
        else if (cfg_idx_i == REG_INTERVAL) rep_iv = cfg_data_i;
      end

      // Input side: update the shadow store, owe a status per query
      if (in_valid_i && in_ready_i) begin
        k = in_data_i.key;
        case (in_data_i.kind)
          KIND_PRESS: begin
            if (k < NUM_KEYS) begin
              raw_lvl[k]   = 1'b1;
              tap_latch[k] = 1'b1;
            end
          end
          KIND_RELEASE: begin
            if (k < NUM_KEYS) raw_lvl[k] = 1'b0;
          end
          KIND_TICK: begin
            // Frame sweep over every key
            for (k = 0; k < NUM_KEYS; k++) begin
              prev_lvl[k] = cur_lvl[k];
              cur_lvl[k]  = raw_lvl[k] | tap_latch[k];
              if (!cur_lvl[k]) held[k] = '0;
              else if (held[k] != HOLD_MAX) held[k] = held[k] + 1'b1;
              tap_latch[k] = 1'b0;
            end
          end
          default: begin
            fresh = '0;
            if (k < NUM_KEYS) begin
              fresh.is_down    = cur_lvl[k];
              fresh.is_push    = push_due(held[k]);
              fresh.is_release = !cur_lvl[k] && prev_lvl[k];
            end
            status_q.push_back(fresh);
          end
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= status_q.size();
      checked_o    <= checked;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the key unit testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;
  import ksa_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 2 * NUM_KEYS + 64;  // one frame sweep and margin
  localparam int unsigned RUN_LIMIT       = 1_000_000;          // cycles
  localparam int unsigned NUM_SETTINGS    = 8;
  localparam int unsigned BEATS_PER_PHASE = 98;
  localparam int unsigned HOT_KEYS        = 6;
  localparam int unsigned STALL_AT_BEAT   = 50;
  localparam int unsigned STALL_CYCLES    = 400;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_WAIT;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  int unsigned fails, pending, checked;

  // Repeat settings walked through after the reset phase (wait, interval)
  int unsigned wait_tab [NUM_SETTINGS] = '{2, 1, 4, 0, 3, 1023, 1, 5};
  int unsigned iv_tab   [NUM_SETTINGS] = '{3, 1, 0, 4, 2, 1023, 1023, 7};

  logic [KEY_W-1:0] hot [HOT_KEYS];
  int unsigned      sent, n_press, n_release, n_tick, n_query;
  bit               send_quiet;

  always #6 clk_i = ~clk_i;

  key_state_autorepeat_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  key_status_checker u_status (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Mostly keys from the small hot set so holds build up, sometimes any key
  function automatic logic [KEY_W-1:0] choose_key();
    if ($urandom_range(0, 99) < 80) return hot[$urandom_range(0, HOT_KEYS - 1)];
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input kind_e kind, input logic [KEY_W-1:0] key);
    int unsigned gap;
    in_item_t    item;
    if (sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    item.kind = kind;
    item.key  = key;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    case (kind)
      KIND_PRESS:   n_press++;
      KIND_RELEASE: n_release++;
      KIND_TICK:    n_tick++;
      default:      n_query++;
    endcase
  endtask

  // Drop valid, wait for every owed status, then let a sweep finish
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result sink: random ready gaps, quiet stretches, one long hold-off
  initial begin : status_sink
    int unsigned gap, beats;
    bit          quiet;
    beats = 0;
    quiet = 1'b0;
    forever begin
      if (beats % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (beats == STALL_AT_BEAT) gap = STALL_CYCLES;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      beats++;
    end
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
    $display("key_state_autorepeat_unit: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned phase, n, pick;
    sent = 0; n_press = 0; n_release = 0; n_tick = 0; n_query = 0;
    send_quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first frame, hold, release edge, sub-frame tap, untouched key
    send_beat(KIND_QUERY, 9'd0);
    send_beat(KIND_PRESS, 9'd0);
    send_beat(KIND_PRESS, 9'd511);
    send_beat(KIND_QUERY, 9'd0);
    send_beat(KIND_TICK, 9'h1ff);
    send_beat(KIND_QUERY, 9'd0);
    send_beat(KIND_QUERY, 9'd511);
    send_beat(KIND_TICK, 9'd0);
    send_beat(KIND_QUERY, 9'd511);
    send_beat(KIND_RELEASE, 9'd0);
    send_beat(KIND_TICK, 9'h0aa);
    send_beat(KIND_QUERY, 9'd0);
    send_beat(KIND_PRESS, 9'h155);
    send_beat(KIND_RELEASE, 9'h155);
    send_beat(KIND_TICK, 9'h155);
    send_beat(KIND_QUERY, 9'h155);
    send_beat(KIND_TICK, 9'd1);
    send_beat(KIND_QUERY, 9'h155);
    send_beat(KIND_QUERY, 9'h0aa);
    send_beat(KIND_RELEASE, 9'd511);
    send_beat(KIND_TICK, 9'd256);
    send_beat(KIND_QUERY, 9'd511);

    // Random phases, one per repeat setting, reset setting first
    for (phase = 0; phase <= NUM_SETTINGS; phase++) begin
      if (phase > 0) begin
        settle();
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= REG_WAIT;
        cfg_data_i <= CFG_W'(wait_tab[phase - 1]);
        @(posedge clk_i);
        cfg_idx_i  <= REG_INTERVAL;
        cfg_data_i <= CFG_W'(iv_tab[phase - 1]);
        @(posedge clk_i);
        cfg_we_i   <= 1'b0;
      end
      for (n = 0; n < HOT_KEYS; n++) hot[n] = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)      send_beat(KIND_TICK, KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
        else if (pick < 40) send_beat(KIND_PRESS, choose_key());
        else if (pick < 50) send_beat(KIND_RELEASE, choose_key());
        else                send_beat(KIND_QUERY, choose_key());
      end
    end

    settle();
    $display("Sent %0d key-down, %0d key-up, %0d frame ticks and %0d queries",
             n_press, n_release, n_tick, n_query);
    $display("over %0d repeat settings; %0d key statuses compared.", NUM_SETTINGS + 1, checked);
    if (fails == 0 && pending == 0) begin
      $display("key_state_autorepeat_unit: match");
    end else begin
      $display("%0d failures, %0d statuses never arrived", fails, pending);
      $display("key_state_autorepeat_unit: mismatch");
    end
    $finish;
  end

endmodule
